// ===== src/eptc_pkg.sv =====
// Package for the exact price-to-tick converter.
// Holds widths, status codes, register indexes and the sequencer state type.
package eptc_pkg;
  localparam int unsigned DataWidth = 64;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusInvalid = 2'd1,
    StatusOffGrid = 2'd2,
    StatusOverflow = 2'd3
  } status_e;

  localparam logic CfgTickNum = 1'b0;
  localparam logic CfgTickDen = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StGcdStep,
    StGcdWait,
    StDivA,
    StDivAWait,
    StDivB,
    StDivBWait,
    StCheck,
    StOvfWait,
    StMul,
    StOut
  } state_e;

  typedef struct packed {
    logic start;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DataWidth-1:0] quotient;
    logic [DataWidth-1:0] remainder;
  } div_rsp_t;
endpackage

// ===== src/exact_price_to_tick_converter_unit.sv =====
// Top level of the exact price-to-tick converter: sequencer, operand
// registers, a shift-add multiplier and the shared divider.
// Depends on eptc_pkg and eptc_divider.
//
// Usage: write the tick numerator (index 0) and the tick denominator (index 1)
// on the configuration channel while the block is idle; both reset to one.
// A configuration write is taken ahead of a waiting price transaction. A price
// transaction enters on in_valid_i/in_ready_o, and one result transaction
// leaves on out_valid_o/out_ready_i with tick_count_o and status_o.
// Each Euclid step of the four gcds is one division on the shared divider,
// and each of the four pairs adds a load and its two cancelling divisions.
// out_valid_o rises in the cycle after acceptance for invalid input; an
// off-grid or zero price ends after the gcds and cancelling divisions, an
// overflow after the overflow division as well, and a valid count after
// that division and a shift-add multiply. One item is in flight at a time;
// the next transaction can be accepted from the cycle after the result is
// taken, if no configuration write is waiting. When the receiver stalls,
// the result holds. After reset the block is idle and ready.
module exact_price_to_tick_converter_unit import eptc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [DataWidth-1:0]        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DataWidth-1:0] price_numerator_i,
  input  logic [DataWidth-1:0]        price_denominator_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataWidth-1:0] tick_count_o,
  output logic [1:0]                  status_o
);
  localparam int unsigned CntWidth = $clog2(DataWidth + 1);
  localparam logic [1:0] PairMagPden  = 2'd0;
  localparam logic [1:0] PairMagTnum  = 2'd1;
  localparam logic [1:0] PairTdenPden = 2'd2;
  localparam logic [1:0] PairTdenTnum = 2'd3;
  localparam logic [DataWidth-1:0] PosLimit = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] NegLimit = {1'b1, {(DataWidth-1){1'b0}}};

  state_e state_q, state_d;
  logic [DataWidth-1:0] tnum_cfg_q, tden_cfg_q;
  logic [DataWidth-1:0] mag_q, pden_q, tnum_q, tden_q;
  logic [DataWidth-1:0] ga_q, gb_q, acc_q, mcand_q, mplier_q;
  logic [1:0]           pair_q;
  logic                 neg_q;
  logic [CntWidth-1:0]  mcnt_q;
  status_e              status_q;
  logic [DataWidth-1:0] count_q;
  div_req_t             dreq;
  div_rsp_t             drsp;
  logic [DataWidth-1:0] pa, pb, limit, acc_sum, pnum_mag;
  logic                 in_bad, off_grid, in_take, cfg_take;

  eptc_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign cfg_ready_o = (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
  assign out_valid_o = (state_q == StOut);
  assign tick_count_o = count_q;
  assign status_o     = status_q;
  assign in_take  = in_valid_i && in_ready_o;
  assign cfg_take = cfg_valid_i && cfg_ready_o;
  assign limit = neg_q ? NegLimit : PosLimit;
  assign acc_sum = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
  assign pnum_mag = price_numerator_i[DataWidth-1]
                    ? (~$unsigned(price_numerator_i) + DataWidth'(1))
                    : $unsigned(price_numerator_i);
  assign in_bad = (price_denominator_i == '0) || (tnum_cfg_q == '0) ||
                  tnum_cfg_q[DataWidth-1] || (tden_cfg_q == '0);
  assign off_grid = (pden_q != DataWidth'(1)) || (tnum_q != DataWidth'(1));

  always_comb begin
    unique case (pair_q)
      PairMagPden:  begin pa = mag_q;  pb = pden_q; end
      PairMagTnum:  begin pa = mag_q;  pb = tnum_q; end
      PairTdenPden: begin pa = tden_q; pb = pden_q; end
      PairTdenTnum: begin pa = tden_q; pb = tnum_q; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_take) begin
        if (in_bad) state_d = StOut;
        else state_d = StLoad;
      end
      StLoad: state_d = StGcdStep;
      StGcdStep: state_d = (gb_q == '0) ? StDivA : StGcdWait;
      StGcdWait: if (drsp.done) state_d = StGcdStep;
      StDivA: state_d = StDivAWait;
      StDivAWait: if (drsp.done) state_d = StDivB;
      StDivB: state_d = StDivBWait;
      StDivBWait: if (drsp.done) state_d = (pair_q == PairTdenTnum) ? StCheck : StLoad;
      StCheck: begin
        if (off_grid || mag_q == '0) state_d = StOut;
        else state_d = StOvfWait;
      end
      StOvfWait: if (drsp.done) state_d = (tden_q > drsp.quotient) ? StOut : StMul;
      StMul: if (mcnt_q == CntWidth'(1)) state_d = StOut;
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    dreq = '0;
    unique case (state_q)
      StGcdStep: if (gb_q != '0) begin
        dreq.start = 1'b1; dreq.dividend = ga_q; dreq.divisor = gb_q;
      end
      StDivA: begin dreq.start = 1'b1; dreq.dividend = pa; dreq.divisor = ga_q; end
      StDivB: begin dreq.start = 1'b1; dreq.dividend = pb; dreq.divisor = ga_q; end
      StCheck: if (!off_grid && mag_q != '0) begin
        dreq.start = 1'b1; dreq.dividend = limit; dreq.divisor = mag_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      tnum_cfg_q <= DataWidth'(1);
      tden_cfg_q <= DataWidth'(1);
      mag_q      <= '0;
      pden_q     <= '0;
      tnum_q     <= '0;
      tden_q     <= '0;
      ga_q       <= '0;
      gb_q       <= '0;
      acc_q      <= '0;
      mcand_q    <= '0;
      mplier_q   <= '0;
      pair_q     <= PairMagPden;
      neg_q      <= 1'b0;
      mcnt_q     <= '0;
      status_q   <= StatusOk;
      count_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_take) begin
        unique case (cfg_index_i)
          CfgTickNum: tnum_cfg_q <= cfg_data_i;
          CfgTickDen: tden_cfg_q <= cfg_data_i;
        endcase
      end
      unique case (state_q)
        StIdle: if (in_take) begin
          neg_q   <= price_numerator_i[DataWidth-1];
          mag_q   <= pnum_mag;
          pden_q  <= price_denominator_i;
          tnum_q  <= tnum_cfg_q;
          tden_q  <= tden_cfg_q;
          pair_q  <= PairMagPden;
          count_q <= '0;
          if (in_bad) status_q <= StatusInvalid;
          else status_q <= StatusOk;
        end
        StLoad: begin ga_q <= pa; gb_q <= pb; end
        StGcdWait: if (drsp.done) begin
          ga_q <= gb_q;
          gb_q <= drsp.remainder;
        end
        StDivAWait: if (drsp.done) begin
          unique case (pair_q)
            PairMagPden, PairMagTnum: mag_q <= drsp.quotient;
            default:                  tden_q <= drsp.quotient;
          endcase
        end
        StDivBWait: if (drsp.done) begin
          unique case (pair_q)
            PairMagPden, PairTdenPden: pden_q <= drsp.quotient;
            default:                   tnum_q <= drsp.quotient;
          endcase
          pair_q <= pair_q + 2'd1;
        end
        StCheck: begin
          if (off_grid) status_q <= StatusOffGrid;
          else status_q <= StatusOk;
        end
        StOvfWait: if (drsp.done) begin
          if (tden_q > drsp.quotient) begin
            status_q <= StatusOverflow;
          end else begin
            mcand_q  <= mag_q;
            mplier_q <= tden_q;
            acc_q    <= '0;
            mcnt_q   <= CntWidth'(DataWidth);
          end
        end
        StMul: begin
          acc_q    <= acc_sum;
          mcand_q  <= {mcand_q[DataWidth-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[DataWidth-1:1]};
          mcnt_q   <= mcnt_q - CntWidth'(1);
          if (mcnt_q == CntWidth'(1)) begin
            count_q <= neg_q ? (~acc_sum + DataWidth'(1)) : acc_sum;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tick_count_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("ready while a result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> tick_count_o == '0)
    else $error("nonzero count with failing status");
endmodule

// ===== src/eptc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on eptc_pkg for the request and response structs.
module eptc_divider import eptc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned CntWidth = $clog2(DataWidth + 1);

  logic [DataWidth-1:0] quot_q, quot_d, den_q, den_d;
  logic [DataWidth:0]   rem_q, rem_d, trial;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;

  assign trial = {rem_q[DataWidth-1:0], quot_q[DataWidth-1]} - {1'b0, den_q};

  always_comb begin
    quot_d = quot_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = CntWidth'(DataWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DataWidth]) begin
        rem_d = {rem_q[DataWidth-1:0], quot_q[DataWidth-1]};
        quot_d = {quot_q[DataWidth-2:0], 1'b0};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[DataWidth-2:0], 1'b1};
      end
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q[DataWidth-1:0];
endmodule
